// ===== sv/ppsb_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsb_pkg
// Shared constants and types of the parallel port to serial bridge.
// ----------------------------------------------------------------------------
package ppsb_pkg;

	localparam int FIFO_DEPTH = 1024;
	localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int LEVEL_W    = 10;
	localparam int TMO_W      = 16;
	localparam int BYTE_W     = 8;

	localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd100;
	localparam logic [BYTE_W-1:0] BYTE_IDLE     = 8'hFF;

	typedef struct packed {
		logic              strobe_n;
		logic              ack_n;
		logic [BYTE_W-1:0] port_data_in;
		logic              port_ninth_bit;
		logic              rx_valid;
		logic [BYTE_W-1:0] rx_byte;
		logic              tx_done;
		logic              timer_tick;
	} in_item_t;

	typedef struct packed {
		logic               busy_res;
		logic               data_ready_n;
		logic [BYTE_W-1:0]  port_data_out;
		logic               port_drive;
		logic               tx_start;
		logic [BYTE_W-1:0]  tx_byte;
		logic               tx_ninth_bit;
		logic               line_enable;
		logic               rx_overflow;
		logic [LEVEL_W-1:0] fifo_level;
	} out_item_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

// ===== sv/ppsb_if.sv =====
// ----------------------------------------------------------------------------
// ppsb interfaces
// Valid/ready channels for sample beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface ppsb_in_if;
	logic                      valid;
	logic                      ready;
	logic                      strobe_n;
	logic                      ack_n;
	logic [ppsb_pkg::BYTE_W-1:0] port_data_in;
	logic                      port_ninth_bit;
	logic                      rx_valid;
	logic [ppsb_pkg::BYTE_W-1:0] rx_byte;
	logic                      tx_done;
	logic                      timer_tick;

	modport source (
		output valid, strobe_n, ack_n, port_data_in, port_ninth_bit,
		       rx_valid, rx_byte, tx_done, timer_tick,
		input  ready
	);
	modport sink (
		input  valid, strobe_n, ack_n, port_data_in, port_ninth_bit,
		       rx_valid, rx_byte, tx_done, timer_tick,
		output ready
	);
endinterface

interface ppsb_out_if;
	logic                         valid;
	logic                         ready;
	logic                         busy_res;
	logic                         data_ready_n;
	logic [ppsb_pkg::BYTE_W-1:0]  port_data_out;
	logic                         port_drive;
	logic                         tx_start;
	logic [ppsb_pkg::BYTE_W-1:0]  tx_byte;
	logic                         tx_ninth_bit;
	logic                         line_enable;
	logic                         rx_overflow;
	logic [ppsb_pkg::LEVEL_W-1:0] fifo_level;

	modport source (
		output valid, busy_res, data_ready_n, port_data_out, port_drive, tx_start,
		       tx_byte, tx_ninth_bit, line_enable, rx_overflow, fifo_level,
		input  ready
	);
	modport sink (
		input  valid, busy_res, data_ready_n, port_data_out, port_drive, tx_start,
		       tx_byte, tx_ninth_bit, line_enable, rx_overflow, fifo_level,
		output ready
	);
endinterface

interface ppsb_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ppsb_pkg::TMO_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== sv/parallel_port_serial_bridge.sv =====
// ----------------------------------------------------------------------------
// parallel_port_serial_bridge
// Host parallel port to 9-bit half-duplex serial link bridge.
// ----------------------------------------------------------------------------
// One sample beat of the port pins, serial status and timer tick is taken per
// clock and gives one result beat of pin values, held in a result register;
// the block sustains one beat per clock, held back only when the result
// register is full and the sink is not ready. Received bytes queue in a
// FIFO_DEPTH-entry memory with one write and one read port; a byte popped for
// the host is read from it in the beat of the pop and is on hand from the next
// cycle, in time for the data pins, which are driven no earlier than the next
// beat. The FIFO holds FIFO_DEPTH - 1 bytes and needs no clearing after reset.
module parallel_port_serial_bridge (
	input logic       clk,
	input logic       arst_n,
	ppsb_in_if.sink   in_ch,
	ppsb_out_if.source out_ch,
	ppsb_cfg_if.sink  cfg
);
	import ppsb_pkg::*;

	in_item_t   item;
	out_item_t  result;
	out_item_t  res_q;
	mem_req_t   mem_req;
	logic [BYTE_W-1:0] mem_rd_data;
	logic       out_valid_q;
	logic       step;

	// result register frees up in the same cycle the sink takes its beat
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign step        = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	always_comb begin
		item.strobe_n       = in_ch.strobe_n;
		item.ack_n          = in_ch.ack_n;
		item.port_data_in   = in_ch.port_data_in;
		item.port_ninth_bit = in_ch.port_ninth_bit;
		item.rx_valid       = in_ch.rx_valid;
		item.rx_byte        = in_ch.rx_byte;
		item.tx_done        = in_ch.tx_done;
		item.timer_tick     = in_ch.timer_tick;
	end

	ppsb_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.result      (result)
	);

	ppsb_ram #(
		.DEPTH  (FIFO_DEPTH),
		.WIDTH  (BYTE_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.busy_res      = res_q.busy_res;
	assign out_ch.data_ready_n  = res_q.data_ready_n;
	assign out_ch.port_data_out = res_q.port_data_out;
	assign out_ch.port_drive    = res_q.port_drive;
	assign out_ch.tx_start      = res_q.tx_start;
	assign out_ch.tx_byte       = res_q.tx_byte;
	assign out_ch.tx_ninth_bit  = res_q.tx_ninth_bit;
	assign out_ch.line_enable   = res_q.line_enable;
	assign out_ch.rx_overflow   = res_q.rx_overflow;
	assign out_ch.fifo_level    = res_q.fifo_level;

endmodule

// ===== sv/ppsb_ram.sv =====
// ----------------------------------------------------------------------------
// ppsb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ppsb_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/ppsb_core.sv =====
// ----------------------------------------------------------------------------
// ppsb_core
// Handshake sequencer, receive FIFO pointers and pin registers.
// ----------------------------------------------------------------------------
module ppsb_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  ppsb_pkg::in_item_t           item,
	input  logic                         cfg_we,
	input  logic [ppsb_pkg::TMO_W-1:0]   cfg_data,
	output ppsb_pkg::mem_req_t           mem_req,
	input  logic [ppsb_pkg::BYTE_W-1:0]  mem_rd_data,
	output ppsb_pkg::out_item_t          result
);
	import ppsb_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TXWAIT  = 3'd1,
		PH_STRWAIT = 3'd2,
		PH_ACK1    = 3'd3,
		PH_ACK2    = 3'd4,
		PH_ACK3    = 3'd5,
		PH_ACK4    = 3'd6
	} phase_t;

	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(FIFO_DEPTH - 1);

	phase_t              phase_q, phase_d;
	logic [ADDR_W-1:0]   wr_idx_q, wr_idx_d;
	logic [ADDR_W-1:0]   rd_idx_q, rd_idx_d;
	logic [TMO_W-1:0]    wait_q, wait_d;
	logic [TMO_W-1:0]    timeout_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                pop_s1;
	logic                busy_q, busy_d;
	logic                ready_q, ready_d;
	logic                drive_q, drive_d;
	logic                line_q, line_d;

	logic                tmo;
	logic                tick_inc;
	logic                pop;
	logic                start;
	logic                full;
	logic                ovf;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_next;
	logic [ADDR_W-1:0]   rd_next;
	logic [ADDR_W:0]     level_ext;
	logic [ADDR_W-1:0]   level;
	logic [BYTE_W-1:0]   out_byte;

	// read data lands in the cycle after the pop
	assign out_byte = pop_s1 ? mem_rd_data : out_byte_q;

	// timed wait: give up on a tick once the count has reached the limit
	assign tmo      = item.timer_tick && (wait_q >= timeout_q);
	assign tick_inc = item.timer_tick && !tmo;

	assign wr_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
	assign full    = (wr_next == rd_idx_q);
	assign ovf     = item.rx_valid && full;
	assign wr_en   = item.rx_valid && !full;

	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		busy_d   = busy_q;
		ready_d  = ready_q;
		drive_d  = drive_q;
		line_d   = line_q;
		rd_idx_d = rd_idx_q;
		pop      = 1'b0;
		start    = 1'b0;
		unique case (phase_q)
			PH_TXWAIT: begin
				if (item.tx_done) begin
					line_d  = 1'b0;
					wait_d  = '0;
					phase_d = PH_STRWAIT;
				end
			end
			PH_STRWAIT: begin
				if (item.strobe_n || tmo) begin
					busy_d  = 1'b0;
					phase_d = PH_IDLE;
				end else if (tick_inc) begin
					wait_d = wait_q + 1'b1;
				end
			end
			PH_ACK1: begin
				if (!item.ack_n || tmo) begin
					drive_d = 1'b1;
					ready_d = 1'b1;
					wait_d  = '0;
					phase_d = PH_ACK2;
				end else if (tick_inc) begin
					wait_d = wait_q + 1'b1;
				end
			end
			PH_ACK2: begin
				if (item.ack_n || tmo) begin
					drive_d = 1'b0;
					ready_d = 1'b0;
					phase_d = PH_ACK3;
				end else if (tick_inc) begin
					wait_d = wait_q + 1'b1;
				end
			end
			PH_ACK3: begin
				// no timeout on this wait
				if (!item.ack_n) begin
					ready_d = 1'b1;
					wait_d  = '0;
					phase_d = PH_ACK4;
				end
			end
			PH_ACK4: begin
				if (item.ack_n || tmo) begin
					phase_d = PH_IDLE;
				end else if (tick_inc) begin
					wait_d = wait_q + 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (!item.strobe_n) begin
					busy_d  = 1'b1;
					line_d  = 1'b1;
					start   = 1'b1;
					phase_d = PH_TXWAIT;
				end else if (wr_idx_q != rd_idx_q) begin
					pop      = 1'b1;
					rd_idx_d = rd_next;
					ready_d  = 1'b0;
					wait_d   = '0;
					phase_d  = PH_ACK1;
				end
			end
		endcase
		wr_idx_d = wr_en ? wr_next : wr_idx_q;
	end

	assign level_ext = (wr_idx_d >= rd_idx_d)
		? {1'b0, wr_idx_d} - {1'b0, rd_idx_d}
		: {1'b0, wr_idx_d} + (ADDR_W + 1)'(FIFO_DEPTH) - {1'b0, rd_idx_d};
	assign level = level_ext[ADDR_W-1:0];

	always_comb begin
		mem_req.wr_en   = step && wr_en;
		mem_req.wr_addr = wr_idx_q;
		mem_req.wr_data = item.rx_byte;
		mem_req.rd_en   = step && pop;
		mem_req.rd_addr = rd_idx_q;
	end

	always_comb begin
		result.busy_res      = busy_d;
		result.data_ready_n  = ready_d;
		result.port_data_out = drive_d ? out_byte : BYTE_IDLE;
		result.port_drive    = drive_d;
		result.tx_start      = start;
		result.tx_byte       = start ? item.port_data_in : '0;
		result.tx_ninth_bit  = start && item.port_ninth_bit;
		result.line_enable   = line_d;
		result.rx_overflow   = ovf;
		result.fifo_level    = LEVEL_W'(level);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			wait_q     <= '0;
			busy_q     <= 1'b0;
			ready_q    <= 1'b1;
			drive_q    <= 1'b0;
			line_q     <= 1'b0;
			pop_s1     <= 1'b0;
			out_byte_q <= BYTE_IDLE;
			timeout_q  <= TIMEOUT_RESET;
		end else begin
			pop_s1 <= mem_req.rd_en;
			if (pop_s1) begin
				out_byte_q <= mem_rd_data;
			end
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (step) begin
				phase_q  <= phase_d;
				wr_idx_q <= wr_idx_d;
				rd_idx_q <= rd_idx_d;
				wait_q   <= wait_d;
				busy_q   <= busy_d;
				ready_q  <= ready_d;
				drive_q  <= drive_d;
				line_q   <= line_d;
			end
		end
	end

	// a pop never reads the slot being filled in the same beat
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
		else $error("fifo read and write hit the same entry");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> wr_idx_q != rd_idx_q)
		else $error("pop from an empty fifo");

	a_drive_in_ack2: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q |-> phase_q == PH_ACK2)
		else $error("data pins driven outside the second ack wait");

	a_line_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		line_q |-> busy_q)
		else $error("line driver on while not busy");

	a_pop_loads_byte: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |=> pop_s1 && !drive_q)
		else $error("popped byte not captured");

endmodule

// ===== verif/parallel_port_serial_bridge_test.sv =====
// ----------------------------------------------------------------------------
// parallel_port_serial_bridge_test
// Self-checking bench for the parallel port to serial bridge: a queue-fed
// sample driver, a result monitor and a cycle-accurate pin predictor. Covers
// strobe transmissions, host handshakes with and without timeouts, FIFO fill
// to overflow and a refill past the write pointer wrap, under several timeouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parallel_port_serial_bridge_test;
	import ppsb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef enum logic [2:0] {
		PH_IDLE, PH_TXWAIT, PH_STRWAIT, PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4
	} link_phase_t;

	logic clk;
	logic arst_n;

	ppsb_in_if  in_ch();
	ppsb_out_if out_ch();
	ppsb_cfg_if cfg();

	parallel_port_serial_bridge u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// predictor state
	link_phase_t        bridge_phase;
	logic [BYTE_W-1:0]  rx_mem [FIFO_DEPTH];
	int unsigned        wr_ptr;
	int unsigned        rd_ptr;
	logic [TMO_W-1:0]   wait_cnt;
	logic [TMO_W-1:0]   tmo_limit;
	logic [BYTE_W-1:0]  held_byte;
	logic               busy_q, rdy_n_q, drive_q, line_q;

	// stimulus and scoreboard
	in_item_t  pending[$];
	out_item_t expected_pins[$];
	in_item_t  sample_now;
	int        queued;
	int        src_idle, snk_idle;
	int        src_max_gap, snk_max_gap;
	int        tick_pct, rx_pct;
	logic      sink_hold;
	int        mismatches;
	int        cycle_count;

	always #5 clk = ~clk;

	function automatic logic wait_gives_up(logic tick);
		if (!tick)
			return 1'b0;
		if (wait_cnt >= tmo_limit)
			return 1'b1;
		wait_cnt = wait_cnt + 1'b1;
		return 1'b0;
	endfunction

	function automatic out_item_t bridge_step(in_item_t s);
		out_item_t   r;
		int unsigned rd_start;
		int unsigned wr_next;
		r = '0;
		rd_start = rd_ptr;
		// the tick only counts while the awaited pin has not answered
		case (bridge_phase)
			PH_TXWAIT: begin
				if (s.tx_done) begin
					line_q = 1'b0;
					wait_cnt = '0;
					bridge_phase = PH_STRWAIT;
				end
			end
			PH_STRWAIT: begin
				if (s.strobe_n ? 1'b1 : wait_gives_up(s.timer_tick)) begin
					busy_q = 1'b0;
					bridge_phase = PH_IDLE;
				end
			end
			PH_ACK1: begin
				if (!s.ack_n ? 1'b1 : wait_gives_up(s.timer_tick)) begin
					drive_q = 1'b1;
					rdy_n_q = 1'b1;
					wait_cnt = '0;
					bridge_phase = PH_ACK2;
				end
			end
			PH_ACK2: begin
				if (s.ack_n ? 1'b1 : wait_gives_up(s.timer_tick)) begin
					drive_q = 1'b0;
					rdy_n_q = 1'b0;
					bridge_phase = PH_ACK3;
				end
			end
			PH_ACK3: begin
				if (!s.ack_n) begin
					rdy_n_q = 1'b1;
					wait_cnt = '0;
					bridge_phase = PH_ACK4;
				end
			end
			PH_ACK4: begin
				if (s.ack_n ? 1'b1 : wait_gives_up(s.timer_tick))
					bridge_phase = PH_IDLE;
			end
			default: begin
				bridge_phase = PH_IDLE;
				if (!s.strobe_n) begin
					busy_q = 1'b1;
					line_q = 1'b1;
					r.tx_start = 1'b1;
					r.tx_byte = s.port_data_in;
					r.tx_ninth_bit = s.port_ninth_bit;
					bridge_phase = PH_TXWAIT;
				end else if (wr_ptr != rd_start) begin
					held_byte = rx_mem[ADDR_W'(rd_start)];
					rd_ptr = (rd_start + 1) % FIFO_DEPTH;
					rdy_n_q = 1'b0;
					wait_cnt = '0;
					bridge_phase = PH_ACK1;
				end
			end
		endcase
		// fullness judged on the read pointer before this sample's pop
		if (s.rx_valid) begin
			wr_next = (wr_ptr + 1) % FIFO_DEPTH;
			if (wr_next == rd_start) begin
				r.rx_overflow = 1'b1;
			end else begin
				rx_mem[ADDR_W'(wr_ptr)] = s.rx_byte;
				wr_ptr = wr_next;
			end
		end
		r.busy_res = busy_q;
		r.data_ready_n = rdy_n_q;
		r.port_data_out = drive_q ? held_byte : BYTE_IDLE;
		r.port_drive = drive_q;
		r.line_enable = line_q;
		r.fifo_level = LEVEL_W'((wr_ptr + FIFO_DEPTH - rd_ptr) % FIFO_DEPTH);
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	function automatic void put(in_item_t s);
		pending.push_back(s);
		queued++;
	endfunction

	function automatic in_item_t rand_sample();
		in_item_t s;
		s.strobe_n = 1'($urandom_range(0, 1));
		s.ack_n = 1'($urandom_range(0, 1));
		s.port_data_in = 8'($urandom_range(0, 255));
		s.port_ninth_bit = 1'($urandom_range(0, 1));
		s.rx_valid = ($urandom_range(0, 99) < rx_pct);
		s.rx_byte = 8'($urandom_range(0, 255));
		s.tx_done = 1'($urandom_range(0, 1));
		s.timer_tick = ($urandom_range(0, 99) < tick_pct);
		return s;
	endfunction

	// strobe, transmit, done, release; sometimes the strobe is held past its timeout
	task automatic push_write_txn();
		in_item_t s;
		int       hold;
		s = rand_sample();
		s.strobe_n = 1'b0;
		put(s);
		repeat ($urandom_range(0, 3)) begin
			s = rand_sample();
			s.strobe_n = 1'b0;
			s.tx_done = 1'b0;
			put(s);
		end
		s = rand_sample();
		s.strobe_n = 1'b0;
		s.tx_done = 1'b1;
		put(s);
		hold = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 2);
		repeat (hold) begin
			s = rand_sample();
			s.strobe_n = 1'b0;
			put(s);
		end
		s = rand_sample();
		s.strobe_n = 1'b1;
		put(s);
	endtask

	// pop sample then ack low, high, low, high; a slow host lags a step
	task automatic push_read_txn(input logic slow);
		in_item_t s;
		logic     lvl;
		s = rand_sample();
		s.strobe_n = 1'b1;
		s.ack_n = 1'b1;
		put(s);
		for (int k = 0; k < 4; k++) begin
			lvl = k[0];
			if (slow && $urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(2, 6)) begin
					s = rand_sample();
					s.strobe_n = 1'b1;
					s.ack_n = !lvl;
					put(s);
				end
			end
			s = rand_sample();
			s.strobe_n = 1'b1;
			s.ack_n = lvl;
			put(s);
		end
	endtask

	task automatic run_random(input int count);
		int goal;
		int pick;
		goal = queued + count;
		while (queued < goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				push_write_txn();
			else if (pick < 8)
				push_read_txn(1'b1);
			else
				repeat ($urandom_range(1, 4)) put(rand_sample());
		end
	endtask

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (pending.size() != 0 || in_ch.valid || expected_pins.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TMO_W-1:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		tmo_limit = v;
	endtask

	// walk the link back to idle with pins that answer each wait
	task automatic bring_to_idle();
		in_item_t s;
		while (bridge_phase != PH_IDLE) begin
			s = '0;
			s.strobe_n = 1'b1;
			s.ack_n = !(bridge_phase == PH_ACK1 || bridge_phase == PH_ACK3);
			s.tx_done = (bridge_phase == PH_TXWAIT);
			@(negedge clk);
			put(s);
			wait_quiet();
		end
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			src_idle = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_pins.push_back(bridge_step(sample_now));
			if (!in_ch.valid || in_ch.ready) begin
				if (src_idle != 0) begin
					src_idle--;
					in_ch.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					sample_now = pending.pop_front();
					in_ch.strobe_n <= sample_now.strobe_n;
					in_ch.ack_n <= sample_now.ack_n;
					in_ch.port_data_in <= sample_now.port_data_in;
					in_ch.port_ninth_bit <= sample_now.port_ninth_bit;
					in_ch.rx_valid <= sample_now.rx_valid;
					in_ch.rx_byte <= sample_now.rx_byte;
					in_ch.tx_done <= sample_now.tx_done;
					in_ch.timer_tick <= sample_now.timer_tick;
					in_ch.valid <= 1'b1;
					src_idle = $urandom_range(0, src_max_gap);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			snk_idle = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pins.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					out_item_t exp_pins;
					exp_pins = expected_pins.pop_front();
					check_field("busy_res", 16'(exp_pins.busy_res), 16'(out_ch.busy_res));
					check_field("data_ready_n", 16'(exp_pins.data_ready_n),
						16'(out_ch.data_ready_n));
					check_field("port_data_out", 16'(exp_pins.port_data_out),
						16'(out_ch.port_data_out));
					check_field("port_drive", 16'(exp_pins.port_drive), 16'(out_ch.port_drive));
					check_field("tx_start", 16'(exp_pins.tx_start), 16'(out_ch.tx_start));
					check_field("tx_byte", 16'(exp_pins.tx_byte), 16'(out_ch.tx_byte));
					check_field("tx_ninth_bit", 16'(exp_pins.tx_ninth_bit),
						16'(out_ch.tx_ninth_bit));
					check_field("line_enable", 16'(exp_pins.line_enable),
						16'(out_ch.line_enable));
					check_field("rx_overflow", 16'(exp_pins.rx_overflow),
						16'(out_ch.rx_overflow));
					check_field("fifo_level", 16'(exp_pins.fifo_level), 16'(out_ch.fifo_level));
				end
				snk_idle = $urandom_range(0, snk_max_gap);
			end
			if (sink_hold) begin
				out_ch.ready <= 1'b0;
			end else if (snk_idle != 0) begin
				snk_idle--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.strobe_n = 1'b1;
		in_ch.ack_n = 1'b1;
		in_ch.port_data_in = '0;
		in_ch.port_ninth_bit = 1'b0;
		in_ch.rx_valid = 1'b0;
		in_ch.rx_byte = '0;
		in_ch.tx_done = 1'b0;
		in_ch.timer_tick = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		sink_hold = 1'b0;
		sample_now = '0;
		queued = 0;
		mismatches = 0;
		cycle_count = 0;
		src_max_gap = 4;
		snk_max_gap = 4;
		tick_pct = 50;
		rx_pct = 30;
		bridge_phase = PH_IDLE;
		wr_ptr = 0;
		rd_ptr = 0;
		wait_cnt = '0;
		tmo_limit = TIMEOUT_RESET;
		held_byte = BYTE_IDLE;
		busy_q = 1'b0;
		rdy_n_q = 1'b1;
		drive_q = 1'b0;
		line_q = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes both ways, full handshakes, strobe over a waiting byte
		@(negedge clk);
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b1});
		put(in_item_t'{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1});
		put(in_item_t'{1'b0, 1'b1, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1});
		put(in_item_t'{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1});
		put(in_item_t'{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0});
		put(in_item_t'{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		// transmit done with nothing in flight is ignored
		put(in_item_t'{1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1});
		put(in_item_t'{1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
		put(in_item_t'{1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0});
		put(in_item_t'{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
		wait_quiet();

		// zero timeout gives up on the first tick
		write_timeout('0);
		@(negedge clk);
		run_random(150);
		wait_quiet();

		// park in transmit wait and flood the FIFO past full, sink held off meanwhile
		write_timeout(16'd1);
		bring_to_idle();
		rx_pct = 100;
		@(negedge clk);
		begin
			in_item_t s;
			s = rand_sample();
			s.strobe_n = 1'b0;
			put(s);
			repeat (FIFO_DEPTH + 16) begin
				s = rand_sample();
				s.tx_done = 1'b0;
				put(s);
			end
		end
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (300) @(posedge clk);
		sink_hold <= 1'b0;
		wait_quiet();

		// pop while still flooding so the write pointer wraps with the fifo at full
		write_timeout(16'hFFFF);
		bring_to_idle();
		@(negedge clk);
		repeat (30) push_read_txn(1'b0);
		wait_quiet();

		// back-to-back stretch with no idling on either side
		write_timeout(16'd3);
		rx_pct = 30;
		src_max_gap = 0;
		snk_max_gap = 0;
		@(negedge clk);
		run_random(100);
		wait_quiet();

		write_timeout(16'($urandom_range(2, 40)));
		src_max_gap = 4;
		snk_max_gap = 4;
		tick_pct = 70;
		@(negedge clk);
		run_random(100);
		wait_quiet();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ppsb_pkg.sv
sv/ppsb_if.sv
sv/ppsb_ram.sv
sv/ppsb_core.sv
sv/parallel_port_serial_bridge.sv
verif/parallel_port_serial_bridge_test.sv
